// ===== hdl/simn_pkg.sv =====
// ---------------------------------------------------------------------------
// simn_pkg
// Shared types and constants for the SAVI index / frame-minimum hue block.
// ---------------------------------------------------------------------------
package simn_pkg;

  // default fraction bits of the fixed-point index
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int DEN_W    = 10;   // 2*n + 2*r + 1, at most 1021
  localparam int MAG3_W   = 10;   // 3*|n - r|, at most 765
  localparam int HUE_W    = 8;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // pass codes carried in tuser
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  localparam logic [HUE_W-1:0] HUE_MAX = {HUE_W{1'b1}};

  // classified pixel, handed from front to back
  typedef struct packed {
    logic              mode;
    logic              first;
    logic              neg;
    logic [MAG3_W-1:0] mag3;
    logic [DEN_W-1:0]  den;
  } simn_item_t;

endpackage

// ===== hdl/simn_front.sv =====
// ---------------------------------------------------------------------------
// simn_front
// Accepts pixel transfers, forms the divider operands and queues them.
// ---------------------------------------------------------------------------
module simn_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [7:0] nir_sample, [15:8] red_sample
  input  logic [1:0]           s_tuser,   // [0] mode, [1] first_of_frame
  output logic                 q_valid,
  input  logic                 q_ready,
  output simn_pkg::simn_item_t q_item
);

  localparam int PW = (simn_pkg::QDEPTH > 1) ? $clog2(simn_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(simn_pkg::QDEPTH + 1);

  logic [simn_pkg::SAMPLE_W-1:0] nir, red, mag;
  simn_pkg::simn_item_t          item_in;
  simn_pkg::simn_item_t          qmem [simn_pkg::QDEPTH];
  logic [PW-1:0]                 wr_ptr, rd_ptr;
  logic [CW-1:0]                 count;
  logic                          push, pop;

  // classify: sign, 3*|n-r| and 2n+2r+1
  always_comb begin
    nir = s_tdata[7:0];
    red = s_tdata[15:8];
    mag = (nir >= red) ? (nir - red) : (red - nir);
    item_in.mode  = s_tuser[0];
    item_in.first = s_tuser[1];
    item_in.neg   = (nir < red);
    item_in.mag3  = {1'b0, mag, 1'b0} + {2'b00, mag};
    item_in.den   = {1'b0, nir, 1'b1} + {1'b0, red, 1'b0};
  end

  assign s_tready = (count != CW'(simn_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = qmem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= item_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(simn_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(simn_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(simn_pkg::QDEPTH))
    else $error("queue count above depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == CW'(simn_pkg::QDEPTH) |-> !push)
    else $error("push into a full queue");

endmodule

// ===== hdl/simn_back.sv =====
// ---------------------------------------------------------------------------
// simn_back
// Restoring divider for the index, frame-minimum tracking and hue output.
// ---------------------------------------------------------------------------
module simn_back #(
  parameter int FRAC_BITS = simn_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  simn_pkg::simn_item_t q_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] hue
  output logic [0:0]           m_tuser    // [0] clipped
);

  localparam int QW = FRAC_BITS + 1;         // quotient magnitude
  localparam int IW = FRAC_BITS + 2;         // signed index
  localparam int DW = FRAC_BITS + 3;         // signed difference
  localparam int VW = FRAC_BITS + 12;        // scaled difference
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int RW = simn_pkg::DEN_W + 1;   // partial remainder
  localparam logic [IW-1:0] MIN_RESET = {1'b0, {(IW-1){1'b1}}};
  localparam logic [VW-1:0] ROUND_C   = VW'(3) << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_FIN   = 5'b00100,
    S_APPLY = 5'b01000,
    S_HUE   = 5'b10000
  } state_t;

  state_t               state;
  simn_pkg::simn_item_t item;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        quo;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        frame_min;
  logic [DW-1:0]        diff;
  logic [IW-1:0]        idx_mag;

  logic                 ge;
  logic [RW-1:0]        r_after;
  logic [VW-1:0]        diff_x, v;
  logic [VW-FRAC_BITS-1:0] raw;
  logic                 over;
  logic [7:0]           hue_val;
  logic                 out_free;

  assign q_ready  = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // one quotient bit per cycle
  always_comb begin
    ge      = (rem >= {1'b0, item.den});
    r_after = ge ? (rem - {1'b0, item.den}) : rem;
    idx_mag = {1'b0, quo};
  end

  // hue = floor((255*diff + 1.5*2^F) / 2^F), saturated
  always_comb begin
    diff_x  = {{(VW-DW){diff[DW-1]}}, diff};
    v       = (diff_x << 8) - diff_x + ROUND_C;
    raw     = v[VW-1:FRAC_BITS];
    over    = !v[VW-1] && (raw[VW-FRAC_BITS-1:8] != '0);
    if (v[VW-1]) begin
      hue_val = '0;
    end else if (over) begin
      hue_val = simn_pkg::HUE_MAX;
    end else begin
      hue_val = raw[7:0];
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frame_min <= MIN_RESET;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            rem   <= {1'b0, q_item.mag3};
            cnt   <= CW'(FRAC_BITS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo <= {quo[QW-2:0], ge};
          rem <= {r_after[RW-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          idx   <= item.neg ? (~idx_mag + 1'b1) : idx_mag;
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (item.mode == simn_pkg::MODE_SCAN) begin
            if (item.first || ($signed(idx) < $signed(frame_min))) begin
              frame_min <= idx;
            end
            state <= S_IDLE;
          end else begin
            diff  <= {idx[IW-1], idx} - {frame_min[IW-1], frame_min};
            state <= S_HUE;
          end
        end
        S_HUE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_HUE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HUE && out_free) begin
      m_tdata <= hue_val;
      m_tuser <= over;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < {item.den, 1'b0})
    else $error("divider remainder out of range");

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == simn_pkg::HUE_MAX)
    else $error("clipped result not saturated");

  a_hue_load: assert property (@(posedge clk) disable iff (rst)
    state == S_HUE && out_free |=> m_tvalid && state == S_IDLE)
    else $error("hue result not loaded");

endmodule

// ===== hdl/savi_index_min_normalize.sv =====
// ---------------------------------------------------------------------------
// savi_index_min_normalize
// SAVI index per pixel, frame-minimum scan pass and hue map pass.
// ---------------------------------------------------------------------------
// A map-pass hue goes through the queue, the back-end states S_IDLE, S_DIV,
// S_FIN, S_APPLY and S_HUE, and the output register. The restoring divider in
// S_DIV gives one quotient bit per cycle; the back end takes no new pixel until
// it is back in S_IDLE, and a two-entry queue takes input while it has room.
// Reset (rst, synchronous) empties the queue, drops the output and loads the
// frame minimum with the most positive index, 2^(FRAC_BITS+1)-1.
module savi_index_min_normalize #(
  parameter int FRAC_BITS = simn_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] nir_sample, [15:8] red_sample
  input  logic [1:0]  s_tuser,   // [0] mode, [1] first_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] hue
  output logic [0:0]  m_tuser    // [0] clipped
);

  logic                 q_valid;
  logic                 q_ready;
  simn_pkg::simn_item_t q_item;

  simn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  simn_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== bench/savi_index_min_normalize_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// savi_index_min_normalize_tb
// Self-checking bench for the SAVI index / frame-minimum hue block.
// ---------------------------------------------------------------------------
// Pixels go in as stream transfers. A monitor on the input side works out
// each pixel's fixed-point index and tracks the frame minimum. For every
// map-pass pixel it queues the expected hue and clip flag. A checker pops one
// expectation for each output transfer and compares hue and clip. The first
// stage is a directed run: corner pixels, a map pass straight out of reset,
// and hues clamped at zero or saturated. Random frames follow, mostly a scan pass
// and then a map pass, with some broken frames and pure noise mixed in.
// Both sides idle at random. One test holds the output off for a long time,
// and another pauses the input until the output has drained.
// ---------------------------------------------------------------------------
module savi_index_min_normalize_tb;

  localparam int FRAC_BITS      = simn_pkg::FRAC_BITS_DEF;
  localparam int SW             = simn_pkg::SAMPLE_W;
  localparam int IDX_W          = FRAC_BITS + 2;
  localparam int PIXEL_CYCLES   = FRAC_BITS + 5;
  localparam int DRAIN_CYCLES   = 4 * PIXEL_CYCLES;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_PRINTED    = 100;
  localparam logic signed [IDX_W-1:0] MIN_RESET = {1'b0, {(IDX_W-1){1'b1}}};

  typedef struct packed {
    logic                       clipped;
    logic [simn_pkg::HUE_W-1:0] hue;
  } hue_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] nir_sample, [15:8] red_sample
  logic [1:0]  s_tuser;   // [0] mode, [1] first_of_frame
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] hue
  logic [0:0]  m_tuser;   // [0] clipped

  logic signed [IDX_W-1:0] frame_min_model;
  hue_result_t             hue_expect_q[$];
  int                      error_count = 0;
  int                      idle_cycles = 0;
  bit                      tx_no_gap   = 1'b0;
  bit                      rx_no_stall = 1'b0;
  bit                      rx_hold_req = 1'b0;

  savi_index_min_normalize dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 1.5*(n-r)/(n+r+0.5) in signed fixed point, truncated toward zero
  function automatic logic signed [IDX_W-1:0] savi_fixed(input logic [SW-1:0] nir,
                                                         input logic [SW-1:0] red);
    logic [simn_pkg::DEN_W-1:0]  den;
    logic [simn_pkg::MAG3_W-1:0] mag3;
    longint unsigned             quo;
    den  = simn_pkg::DEN_W'(2 * nir + 2 * red + 1);
    mag3 = simn_pkg::MAG3_W'(3 * ((nir >= red) ? nir - red : red - nir));
    quo  = (longint'(mag3) << FRAC_BITS) / den;
    return (nir >= red) ? IDX_W'(quo) : -IDX_W'(quo);
  endfunction

  // floor(255*(idx - min) + 1.5), saturated to a byte
  function automatic hue_result_t map_hue(input logic signed [IDX_W-1:0] idx);
    longint      acc;
    hue_result_t res;
    acc = (longint'(idx) - longint'(frame_min_model)) * 255
          + (longint'(3) <<< (FRAC_BITS - 1));
    res.hue     = '0;
    res.clipped = 1'b0;
    if (acc >= 0) begin
      if ((acc >>> FRAC_BITS) > 255) begin
        res.hue     = simn_pkg::HUE_MAX;
        res.clipped = 1'b1;
      end else begin
        res.hue = simn_pkg::HUE_W'(acc >>> FRAC_BITS);
      end
    end
    return res;
  endfunction

  // input monitor: update the minimum or queue a hue per accepted pixel
  always @(posedge clk) begin : pixel_monitor
    logic signed [IDX_W-1:0] idx;
    if (rst) begin
      frame_min_model = MIN_RESET;
    end else if (s_tvalid && s_tready) begin
      idx = savi_fixed(s_tdata[7:0], s_tdata[15:8]);
      if (s_tuser[0] == simn_pkg::MODE_SCAN) begin
        if (s_tuser[1] || idx < frame_min_model) frame_min_model = idx;
      end else begin
        hue_expect_q.push_back(map_hue(idx));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // compare each output transfer against the oldest expectation
  always @(posedge clk) begin : hue_checker
    hue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (hue_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hue %0d clipped %0b", m_tdata, m_tuser));
      end else begin
        want = hue_expect_q.pop_front();
        if (m_tdata !== want.hue)
          report_mismatch($sformatf("hue got %0d want %0d", m_tdata, want.hue));
        if (m_tuser[0] !== want.clipped)
          report_mismatch($sformatf("clipped got %b want %b (hue %0d)",
                                    m_tuser[0], want.clipped, want.hue));
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin : stall_watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_no_stall ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // one pixel transfer; valid stays high when the next one follows at once
  task automatic send_pixel(input logic mode, input logic first,
                            input logic [SW-1:0] nir, input logic [SW-1:0] red);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {red, nir};
    s_tuser  <= {first, mode};
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // drop valid and wait until every queued hue has come out
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hue_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] clamp_byte(input int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : SW'(v);
  endfunction

  function automatic logic [SW-1:0] extreme_byte();
    int pick;
    pick = $urandom_range(0, 2);
    return (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : SW'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // map pass straight out of reset: minimum still at its most positive value
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd0, 8'd0);
    send_pixel(simn_pkg::MODE_MAP, 1'b1, 8'd255, 8'd0);    // first flag ignored in map pass
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd0, 8'd255);
    // most negative index seeds the minimum, larger ones leave it alone
    send_pixel(simn_pkg::MODE_SCAN, 1'b1, 8'd0, 8'd255);
    send_pixel(simn_pkg::MODE_SCAN, 1'b0, 8'd255, 8'd0);
    send_pixel(simn_pkg::MODE_SCAN, 1'b0, 8'd128, 8'd128);
    send_pixel(simn_pkg::MODE_SCAN, 1'b0, 8'd255, 8'd255);
    // far above the minimum saturates, the minimum pixel itself maps to one
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd255, 8'd0);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd0, 8'd255);
    send_pixel(simn_pkg::MODE_MAP, 1'b1, 8'd128, 8'd128);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd255, 8'd254);
    // new frame seeded with the most positive index
    send_pixel(simn_pkg::MODE_SCAN, 1'b1, 8'd255, 8'd0);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd0, 8'd255);    // far below: hue 0, no clip
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd255, 8'd0);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd254, 8'd0);
    // later scan pixels pull the minimum down to zero
    send_pixel(simn_pkg::MODE_SCAN, 1'b0, 8'd200, 8'd200);
    send_pixel(simn_pkg::MODE_SCAN, 1'b0, 8'd201, 8'd200);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd201, 8'd200);  // small steps above the minimum
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd203, 8'd200);
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd200, 8'd203);  // just below the minimum
    send_pixel(simn_pkg::MODE_MAP, 1'b0, 8'd0, 8'd0);
  endtask

  // scan pass then map pass over the same pixels, with some broken frames
  task automatic test_random_frames(input int pixel_budget);
    int            sent;
    int            len;
    int            kind;
    int            base_n;
    int            base_r;
    int            j;
    bit            skip_scan;
    bit            no_seed;
    logic [SW-1:0] nir_q[$];
    logic [SW-1:0] red_q[$];
    sent = 0;
    while (sent < pixel_budget) begin
      len         = $urandom_range(1, 12);
      kind        = $urandom_range(0, 3);
      base_n      = $urandom_range(0, 255);
      base_r      = (kind == 2) ? base_n : $urandom_range(0, 255);
      tx_no_gap   = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      skip_scan   = ($urandom_range(0, 9) == 0);
      no_seed     = ($urandom_range(0, 9) == 0);
      nir_q.delete();
      red_q.delete();
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: begin
            nir_q.push_back(SW'($urandom_range(0, 255)));
            red_q.push_back(SW'($urandom_range(0, 255)));
          end
          3: begin
            nir_q.push_back(extreme_byte());
            red_q.push_back(extreme_byte());
          end
          // clustered near a base pixel: hues spread below saturation
          default: begin
            nir_q.push_back(clamp_byte(base_n + int'($urandom_range(0, 16)) - 8));
            red_q.push_back(clamp_byte(base_r + int'($urandom_range(0, 16)) - 8));
          end
        endcase
      end
      if (!skip_scan) begin
        for (int i = 0; i < len; i++)
          send_pixel(simn_pkg::MODE_SCAN, (i == 0) && !no_seed, nir_q[i], red_q[i]);
      end
      for (int i = 0; i < len; i++) begin
        j = $urandom_range(0, len - 1);
        send_pixel(simn_pkg::MODE_MAP, ($urandom_range(0, 7) == 0), nir_q[j], red_q[j]);
      end
      sent += skip_scan ? len : 2 * len;
    end
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  // any field, any order
  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 SW'($urandom_range(0, 255)), SW'($urandom_range(0, 255)));
  endtask

  // output held off for a long stretch while the input keeps offering pixels
  task automatic test_output_backpressure();
    tx_no_gap   = 1'b1;
    rx_hold_req = 1'b1;
    send_pixel(simn_pkg::MODE_SCAN, 1'b1, 8'd90, 8'd60);
    for (int i = 0; i < 11; i++)
      send_pixel(simn_pkg::MODE_MAP, 1'b0, SW'(80 + i), SW'(60 + $urandom_range(0, 3)));
    tx_no_gap = 1'b0;
  endtask

  // short frames with the input paused until the output has drained
  task automatic test_sender_pause();
    int base_v;
    for (int f = 0; f < 3; f++) begin
      base_v = $urandom_range(20, 235);
      for (int i = 0; i < 3; i++)
        send_pixel(simn_pkg::MODE_SCAN, i == 0, clamp_byte(base_v + i),
                   clamp_byte(base_v - i));
      for (int i = 0; i < 3; i++)
        send_pixel(simn_pkg::MODE_MAP, 1'b0, clamp_byte(base_v + 2 - i),
                   clamp_byte(base_v + i - 2));
      wait_results_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_frames(300);
    test_output_backpressure();
    test_sender_pause();
    test_random_noise(50);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
